### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types of the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int PAYLOAD_BYTES = 48;
  localparam int WORDS         = PAYLOAD_BYTES / 4;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES);
  localparam int WIDX_W        = $clog2(WORDS);
  localparam int RAM_AW        = WIDX_W + 1;
  localparam int RAM_DEPTH     = 2 ** RAM_AW;
  localparam int WORD_W        = 32;
  localparam int SUM_W         = 64;
  localparam int DIFF_W        = 18;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST,
    REG_HEADER_SECOND,
    REG_ENCODER_LIMIT,
    REG_EQUALIZE_WINDOW
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] encoder_limit;
    logic [7:0]  equalize_window;
  } cfg_t;

  typedef struct packed {
    logic              bank;
    logic [WORD_W-1:0] left_raw;
    logic [WORD_W-1:0] right_raw;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front
// Byte intake: header detection, payload capture, word assembly into the
// frame buffer and hand-off of completed frames to the job queue.
// ----------------------------------------------------------------------------
module sfr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  sfr_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  output sfr_pkg::ram_wr_t wr,
  output logic           job_push,
  output sfr_pkg::job_t  job
);

  import sfr_pkg::*;

  logic [7:0]        hist0_r, hist1_r, hist2_r;
  logic              capturing_r;
  logic [CNT_W-1:0]  count_r;
  logic              bank_r;
  logic [23:0]       part_r;
  logic [WORD_W-1:0] left_raw_r, right_raw_r;

  logic              hdr;
  logic              cap;
  logic [CNT_W-1:0]  pos;
  logic [1:0]        lane;
  logic [CNT_W-3:0]  widx;
  logic [WORD_W-1:0] word;
  logic              done;
  logic              word_end;

  always_comb begin
    hdr      = (hist2_r == cfg.header_first) && (hist1_r == cfg.header_second);
    cap      = hdr || capturing_r;
    pos      = hdr ? '0 : count_r;
    lane     = pos[1:0];
    widx     = pos[CNT_W-1:2];
    word     = {rx_byte, part_r};
    done     = cap && (pos == CNT_W'(PAYLOAD_BYTES - 1));
    word_end = cap && (lane == 2'd3) && ({1'b0, pos} < (CNT_W + 1)'(4 * WORDS));
  end

  assign wr.en    = accept && word_end;
  assign wr.addr  = {bank_r, widx[WIDX_W-1:0]};
  assign wr.data  = word;

  assign job_push = accept && done;
  assign job      = '{bank: bank_r, left_raw: left_raw_r, right_raw: right_raw_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r     <= '0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      capturing_r <= 1'b0;
      count_r     <= '0;
      bank_r      <= 1'b0;
    end else if (accept) begin
      if (done) begin
        hist0_r     <= '0;
        hist1_r     <= '0;
        hist2_r     <= '0;
        capturing_r <= 1'b0;
        count_r     <= '0;
        bank_r      <= ~bank_r;
      end else begin
        hist2_r     <= hist1_r;
        hist1_r     <= hist0_r;
        hist0_r     <= rx_byte;
        capturing_r <= cap;
        count_r     <= cap ? pos + CNT_W'(1) : count_r;
      end
    end
  end

  // partial word and encoder words
  always_ff @(posedge clk) begin
    if (accept && cap) begin
      case (lane)
        2'd0: part_r[7:0]   <= rx_byte;
        2'd1: part_r[15:8]  <= rx_byte;
        2'd2: part_r[23:16] <= rx_byte;
        default: begin
          if (widx == '0) begin
            left_raw_r <= word;
          end
          if (widx == (CNT_W - 2)'(1)) begin
            right_raw_r <= word;
          end
        end
      endcase
    end
  end

endmodule

### rtl/sfr_job_queue.sv
// ----------------------------------------------------------------------------
// sfr_job_queue
// Two-entry queue of completed frames between intake and emission.
// ----------------------------------------------------------------------------
module sfr_job_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::job_t     job_in,
  input  logic              pop,
  output sfr_pkg::job_t     head,
  output sfr_pkg::q_stat_t  stat
);

  import sfr_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head       = ent_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back
// Frame emission: encoder limit and equalize rules, running totals and the
// word-by-word output register.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sfr_pkg::cfg_t                cfg,
  input  sfr_pkg::job_t                head,
  input  sfr_pkg::q_stat_t             stat,
  input  logic [sfr_pkg::WORD_W-1:0]   rdata,
  output logic [sfr_pkg::RAM_AW-1:0]   raddr,
  output logic                         job_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [3:0]                   word_index,
  output logic [31:0]                  word_value,
  output logic signed [63:0]           left_total,
  output logic signed [63:0]           right_total,
  output logic                         last_word
);

  import sfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIMIT,
    S_EQUAL,
    S_SUM,
    S_READ,
    S_LOAD
  } state_t;

  state_t            state_r;
  logic [WORD_W-1:0] left_r, right_r;
  logic [SUM_W-1:0]  lsum_r, rsum_r;
  logic [WIDX_W-1:0] k_r;
  logic              out_valid_r;
  logic [3:0]        idx_r;
  logic [31:0]       val_r;
  logic              last_r;
  logic [SUM_W-1:0]  ltot_r, rtot_r;

  logic                     load;
  logic                     last_k;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] neg_win;
  logic [WORD_W-1:0]        emit_val;

  function automatic logic [WORD_W-1:0] limit_count(logic [WORD_W-1:0] c,
                                                    logic [15:0] lim);
    logic signed [WORD_W:0] cs;
    logic signed [WORD_W:0] ls;
    cs = $signed({c[WORD_W-1], c});
    ls = $signed({17'b0, lim});
    if (cs > ls || cs < -ls) begin
      return '0;
    end
    return c;
  endfunction

  always_comb begin
    load     = (state_r == S_LOAD) && (!out_valid_r || pop);
    last_k   = (k_r == WIDX_W'(WORDS - 1));
    diff     = $signed(right_r[DIFF_W-1:0]) - $signed(left_r[DIFF_W-1:0]);
    neg_win  = -$signed({{(DIFF_W - 8){1'b0}}, cfg.equalize_window});
    if (k_r == '0) begin
      emit_val = left_r;
    end else if (k_r == WIDX_W'(1)) begin
      emit_val = right_r;
    end else begin
      emit_val = rdata;
    end
  end

  assign raddr       = {head.bank, k_r};
  assign job_pop     = load && last_k;
  assign empty       = ~out_valid_r;
  assign word_index  = idx_r;
  assign word_value  = val_r;
  assign left_total  = $signed(ltot_r);
  assign right_total = $signed(rtot_r);
  assign last_word   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lsum_r      <= '0;
      rsum_r      <= '0;
      k_r         <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= 4'(k_r);
        val_r       <= emit_val;
        last_r      <= last_k;
        ltot_r      <= lsum_r;
        rtot_r      <= rsum_r;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!stat.empty) begin
            state_r <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          left_r  <= limit_count(head.left_raw, cfg.encoder_limit);
          right_r <= limit_count(head.right_raw, cfg.encoder_limit);
          state_r <= S_EQUAL;
        end
        S_EQUAL: begin
          if (diff < 0 && diff > neg_win) begin
            left_r <= right_r;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          lsum_r  <= lsum_r + {{(SUM_W - WORD_W){left_r[WORD_W-1]}}, left_r};
          rsum_r  <= rsum_r + {{(SUM_W - WORD_W){right_r[WORD_W-1]}}, right_r};
          k_r     <= '0;
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          if (load) begin
            if (last_k) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + WIDX_W'(1);
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/sensor_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_receiver_unit
// Header-synchronized serial frame parser with encoder post-processing.
// ----------------------------------------------------------------------------
// Each received byte is taken while push is high and full is low. Once a
// frame of 48 payload bytes completes, its 12 words are emitted through a
// one-word output register: encoder limit, equalize and sum steps, then a
// frame buffer read and an output load per word, held while pop is low and
// a word waits. The frame buffer has two banks, so intake keeps running while
// a frame is emitted; full is high while two completed frames are queued.
module sensor_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [3:0]                    out_word_index,
  output logic [31:0]                   out_word_value,
  output logic signed [63:0]            out_left_total,
  output logic signed [63:0]            out_right_total,
  output logic                          out_last_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0]    paddr,
  input  logic [sfr_pkg::CFG_DW-1:0]    pwdata,
  output logic [sfr_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  import sfr_pkg::*;

  cfg_t              cfg_r;
  reg_idx_t          ridx;
  logic              cfg_we;
  logic              accept;
  ram_wr_t           wr;
  logic              job_push;
  job_t              job;
  job_t              head;
  q_stat_t           stat;
  logic              job_pop;
  logic [RAM_AW-1:0] raddr;
  logic [WORD_W-1:0] rdata;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first    <= 8'hA5;
      cfg_r.header_second   <= 8'h5A;
      cfg_r.encoder_limit   <= 16'd220;
      cfg_r.equalize_window <= 8'd4;
    end else if (cfg_we) begin
      unique case (ridx)
        REG_HEADER_FIRST:    cfg_r.header_first    <= pwdata[7:0];
        REG_HEADER_SECOND:   cfg_r.header_second   <= pwdata[7:0];
        REG_ENCODER_LIMIT:   cfg_r.encoder_limit   <= pwdata[15:0];
        REG_EQUALIZE_WINDOW: cfg_r.equalize_window <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_HEADER_FIRST:    prdata = {24'b0, cfg_r.header_first};
      REG_HEADER_SECOND:   prdata = {24'b0, cfg_r.header_second};
      REG_ENCODER_LIMIT:   prdata = {16'b0, cfg_r.encoder_limit};
      REG_EQUALIZE_WINDOW: prdata = {24'b0, cfg_r.equalize_window};
      default:             prdata = '0;
    endcase
  end

  assign full   = stat.full;
  assign accept = push && !full;

  sfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .wr       (wr),
    .job_push (job_push),
    .job      (job)
  );

  sfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_frame_buf (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  sfr_job_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .job_in (job),
    .pop    (job_pop),
    .head   (head),
    .stat   (stat)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .stat        (stat),
    .rdata       (rdata),
    .raddr       (raddr),
    .job_pop     (job_pop),
    .pop         (pop),
    .empty       (empty),
    .word_index  (out_word_index),
    .word_value  (out_word_value),
    .left_total  (out_left_total),
    .right_total (out_right_total),
    .last_word   (out_last_word)
  );

  // last word of a frame carries the top index
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_word |-> out_word_index == 4'(WORDS - 1))
    else $error("last word with wrong index");

  // words of a frame leave in order
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_last_word |=>
      empty || out_word_index == $past(out_word_index) + 4'd1)
    else $error("word index out of sequence");

  // a frame cannot be queued while the queue is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !job_push)
    else $error("frame queue overflow");

  // reset leaves both channels idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("not idle after reset");

endmodule
